FILE: rtl/efd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package efd_pkg;

	localparam int MAX_WIDTH = 4096;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int LW_W      = 13;
	localparam int THR_W     = 8;
	localparam int PIX_W     = 8;
	localparam int ERR_W     = 14;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam logic [THR_W-1:0] THRESHOLD_RESET  = 8'd128;
	localparam logic [LW_W-1:0]  LINE_WIDTH_RESET = 13'd640;

	typedef enum logic [0:0] {
		REG_THRESHOLD  = 1'b0,
		REG_LINE_WIDTH = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [THR_W-1:0] threshold;
		logic [COL_W-1:0] last_col;
	} cfg_t;

endpackage

`default_nettype wire

FILE: rtl/efd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface efd_pix_if;
	logic                        valid;
	logic                        ready;
	logic [efd_pkg::PIX_W-1:0]   pixel;
	logic                        first_of_image;

	modport source (output valid, pixel, first_of_image, input ready);
	modport sink   (input valid, pixel, first_of_image, output ready);
endinterface

interface efd_res_if;
	logic valid;
	logic ready;
	logic white;

	modport source (output valid, white, input ready);
	modport sink   (input valid, white, output ready);
endinterface

`default_nettype wire

FILE: rtl/efd_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module efd_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [efd_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [efd_pkg::PDATA_W-1:0]   pwdata,
	output logic      [efd_pkg::PDATA_W-1:0]   prdata,
	output logic                               pready,
	output efd_pkg::cfg_t                      cfg
);

	logic [efd_pkg::THR_W-1:0] threshold_q;
	logic [efd_pkg::LW_W-1:0]  line_width_q;
	logic [efd_pkg::COL_W-1:0] last_col_q;
	logic [efd_pkg::LW_W-1:0]  wr_lw;
	logic [efd_pkg::COL_W-1:0] wr_last_col;
	efd_pkg::reg_idx_t         idx;
	logic                      wr_en;

	assign pready = 1'b1;
	assign idx    = efd_pkg::reg_idx_t'(paddr[2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign wr_lw  = pwdata[efd_pkg::LW_W-1:0];

	// clamp the width to 1..MAX_WIDTH and keep the index of the last column
	always_comb begin
		if (wr_lw == '0) begin
			wr_last_col = '0;
		end else if (wr_lw > efd_pkg::LW_W'(efd_pkg::MAX_WIDTH)) begin
			wr_last_col = efd_pkg::COL_W'(efd_pkg::MAX_WIDTH - 1);
		end else begin
			wr_last_col = efd_pkg::COL_W'(wr_lw - efd_pkg::LW_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= efd_pkg::THRESHOLD_RESET;
			line_width_q <= efd_pkg::LINE_WIDTH_RESET;
			last_col_q   <= efd_pkg::COL_W'(efd_pkg::LINE_WIDTH_RESET - efd_pkg::LW_W'(1));
		end else if (wr_en) begin
			case (idx)
				efd_pkg::REG_THRESHOLD: begin
					threshold_q <= pwdata[efd_pkg::THR_W-1:0];
				end
				efd_pkg::REG_LINE_WIDTH: begin
					line_width_q <= wr_lw;
					last_col_q   <= wr_last_col;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			efd_pkg::REG_THRESHOLD:  prdata = efd_pkg::PDATA_W'(threshold_q);
			efd_pkg::REG_LINE_WIDTH: prdata = efd_pkg::PDATA_W'(line_width_q);
			default:                 prdata = '0;
		endcase
	end

	assign cfg.threshold = threshold_q;
	assign cfg.last_col  = last_col_q;

endmodule

`default_nettype wire

FILE: rtl/error_diffusion_dither.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake      Payload
// pix       in         valid/ready    pixel[7:0], first_of_image
// res       out        valid/ready    white
// apb       cfg        psel/penable   paddr[2:0], pwdata[31:0], prdata[31:0]
//
// One pixel per clock sustained while res is ready; a pixel's result is
// offered once it has passed the row-buffer read into stage 1 and then the
// decision into the output register.
// The row buffer of error sums is one 4096 x 14 memory, one read and one
// write port; the right-neighbour carry closes its loop inside stage 1.
// Reset clears control and carries; row-buffer contents are not cleared.
// A stall on res holds a full stage 1 and drops pix.ready in the same cycle.

module error_diffusion_dither (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	efd_pix_if.sink                            pix,
	efd_res_if.source                          res,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [efd_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [efd_pkg::PDATA_W-1:0]   pwdata,
	output logic      [efd_pkg::PDATA_W-1:0]   prdata,
	output logic                               pready
);

	localparam int COL_W = efd_pkg::COL_W;
	localparam int ERR_W = efd_pkg::ERR_W;

	efd_pkg::cfg_t cfg;

	efd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// row buffer: error sums for the next row, in sixteenths
	logic signed [ERR_W-1:0] row_mem [efd_pkg::MAX_WIDTH];

	// stage 0: column tracking at the transaction, row-buffer read issue
	logic [COL_W-1:0] column_q;
	logic             on_first_row_q;
	logic [COL_W-1:0] col0;
	logic             ofr0;
	logic             last0;
	logic             accept;

	// stage 1
	logic                         valid_s1;
	logic [efd_pkg::PIX_W-1:0]    pix_s1;
	logic [COL_W-1:0]             col_s1;
	logic                         ofr_s1;
	logic                         last_s1;
	logic                         first_s1;
	logic signed [ERR_W-1:0]      rd_s1;
	logic                         s1_adv;

	// forwarding of writes that the registered read missed
	logic                         fwd_hit_q;
	logic signed [ERR_W-1:0]      fwd_data_q;
	logic                         now_hit;

	// carries between neighbouring pixels
	logic signed [ERR_W-1:0]      right_carry_q;
	logic signed [ERR_W-1:0]      below_q;
	logic signed [ERR_W-1:0]      below_left_q;

	// deferred write of the last column's sum
	logic                         tail_pend_q;
	logic [COL_W-1:0]             tail_addr_q;
	logic signed [ERR_W-1:0]      tail_data_q;

	// output register
	logic                         out_valid_q;
	logic                         white_q;

	// stage 1 datapath
	logic signed [ERR_W-1:0]      mem_val;
	logic signed [ERR_W-1:0]      carry_in;
	logic signed [ERR_W-1:0]      bp_in;
	logic signed [ERR_W-1:0]      blp_in;
	logic signed [ERR_W:0]        incoming;
	logic signed [ERR_W:0]        biased;
	logic signed [10:0]           quot;
	logic signed [10:0]           adjusted;
	logic signed [10:0]           err;
	logic                         is_white;
	logic signed [ERR_W-1:0]      err_x;
	logic signed [ERR_W-1:0]      e3;
	logic signed [ERR_W-1:0]      e5;
	logic signed [ERR_W-1:0]      e7;
	logic signed [ERR_W-1:0]      below_wr;
	logic signed [ERR_W-1:0]      blp_new;

	// write port
	logic                         s1_wr;
	logic                         we;
	logic [COL_W-1:0]             waddr;
	logic signed [ERR_W-1:0]      wdata;

	// advance stage 1 when the output register is free or being drained
	assign s1_adv    = valid_s1 && (!out_valid_q || res.ready);
	assign pix.ready = !valid_s1 || s1_adv;
	assign accept    = pix.valid && pix.ready;

	// a new image restarts at column 0 on the first row
	assign col0  = pix.first_of_image ? '0 : column_q;
	assign ofr0  = pix.first_of_image || on_first_row_q;
	assign last0 = (col0 >= cfg.last_col);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q       <= '0;
			on_first_row_q <= 1'b1;
		end else if (accept) begin
			column_q       <= last0 ? '0 : col0 + COL_W'(1);
			on_first_row_q <= last0 ? 1'b0 : ofr0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1   <= pix.pixel;
			col_s1   <= col0;
			ofr_s1   <= ofr0;
			last_s1  <= last0;
			first_s1 <= pix.first_of_image;
		end
	end

	// row buffer: read at the transaction, write from stage 1 or the tail
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= row_mem[col0];
		end
		if (we) begin
			row_mem[waddr] <= wdata;
		end
	end

	// capture a write to the entry being read, or to the entry held in stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
		end else if (accept) begin
			fwd_hit_q <= we && (waddr == col0);
		end else if (now_hit) begin
			fwd_hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && we && (waddr == col0)) begin
			fwd_data_q <= wdata;
		end else if (!accept && now_hit) begin
			fwd_data_q <= tail_data_q;
		end
	end

	// the stage 1 write never targets its own column; only the tail can
	assign now_hit = valid_s1 && tail_pend_q && (tail_addr_q == col_s1);

	always_comb begin
		if (now_hit) begin
			mem_val = tail_data_q;
		end else if (fwd_hit_q) begin
			mem_val = fwd_data_q;
		end else begin
			mem_val = rd_s1;
		end
	end

	// drop the carries at the start of an image
	assign carry_in = first_s1 ? '0 : right_carry_q;
	assign bp_in    = first_s1 ? '0 : below_q;
	assign blp_in   = first_s1 ? '0 : below_left_q;

	always_comb begin
		incoming = {carry_in[ERR_W-1], carry_in};
		if (!ofr_s1) begin
			incoming = incoming + {mem_val[ERR_W-1], mem_val};
		end
		// divide by 16, truncating toward zero
		biased   = incoming + (incoming[ERR_W] ? (ERR_W+1)'(15) : '0);
		quot     = 11'(biased >>> 4);
		adjusted = quot + $signed({3'b000, pix_s1});
		is_white = adjusted > $signed({3'b000, cfg.threshold});
		err      = adjusted - (is_white ? 11'sd255 : 11'sd0);
		err_x    = {{(ERR_W-11){err[10]}}, err};
		e3       = (err_x <<< 1) + err_x;
		e5       = (err_x <<< 2) + err_x;
		e7       = (err_x <<< 3) - err_x;
		below_wr = blp_in + e3;
		blp_new  = bp_in + e5;
	end

	// lower-left write for every column but the first; tail goes next cycle,
	// when stage 1 is empty or holds a column-0 pixel that writes nothing
	assign s1_wr = s1_adv && (col_s1 != '0);
	assign we    = s1_wr || tail_pend_q;

	always_comb begin
		if (s1_wr) begin
			waddr = col_s1 - COL_W'(1);
			wdata = below_wr;
		end else begin
			waddr = tail_addr_q;
			wdata = tail_data_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_pend_q <= 1'b0;
		end else begin
			tail_pend_q <= s1_adv && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && last_s1) begin
			tail_addr_q <= col_s1;
			tail_data_q <= blp_new;
		end
	end

	// advance the carries; clear them at the end of a row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_carry_q <= '0;
			below_q       <= '0;
			below_left_q  <= '0;
		end else if (s1_adv) begin
			if (last_s1) begin
				right_carry_q <= '0;
				below_q       <= '0;
				below_left_q  <= '0;
			end else begin
				right_carry_q <= e7;
				below_q       <= err_x;
				below_left_q  <= blp_new;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			white_q <= is_white;
		end
	end

	assign res.valid = out_valid_q;
	assign res.white = white_q;

endmodule

`default_nettype wire

FILE: sim/tb_error_diffusion_dither.sv
`timescale 1ns / 1ps

module tb_error_diffusion_dither;
	import efd_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_ITEMS   = 1300;
	localparam int STEADY_TAIL    = 200;
	localparam int MAX_REPORTS    = 30;

	// One pixel transaction as the source side offers it.
	typedef struct {
		logic [PIX_W-1:0] pixel;
		logic             first_of_image;
	} pixel_txn_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	efd_pix_if pix ();
	efd_res_if res ();

	error_diffusion_dither DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix     (pix),
		.res     (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// Pixels waiting to be offered, and the black/white decisions predicted for
	// pixels already taken by the block, oldest first.
	pixel_txn_t pixels_to_send[$];
	bit         expected_white[$];

	int mismatch_count = 0;
	int items_queued   = 0;
	int results_seen   = 0;
	int src_gap        = 0;
	int dst_gap        = 0;
	int idle_cycles    = 0;
	// Set while neither side may idle.
	bit steady         = 1'b0;

	// Register shadows, kept in step with every APB write.
	logic [THR_W-1:0] threshold_reg  = THRESHOLD_RESET;
	logic [LW_W-1:0]  line_width_reg = LINE_WIDTH_RESET;

	// Dither state: error sums for the next row in sixteenths, plus the
	// carries from the previous pixel of the current row.
	logic signed [ERR_W-1:0] row_sums [MAX_WIDTH];
	int unsigned col_pos        = 0;
	bit          top_row        = 1'b1;
	int          right_err      = 0;
	int          below_err      = 0;
	int          below_left_err = 0;

	// Clamp the programmed row length to what the row buffer holds.
	function automatic int unsigned effective_width(input logic [LW_W-1:0] raw);
		if (raw == 0) return 1;
		if (raw > MAX_WIDTH) return MAX_WIDTH;
		return raw;
	endfunction

	// Dither one pixel: add the diffused error, decide, spread the new error.
	function automatic bit dither_pixel(input logic [PIX_W-1:0] pixel, input logic first);
		int unsigned w;
		bit          at_end;
		bit          is_white;
		int          incoming;
		int          adjusted;
		int          qerr;

		w = effective_width(line_width_reg);
		if (first) begin
			col_pos        = 0;
			top_row        = 1'b1;
			right_err      = 0;
			below_err      = 0;
			below_left_err = 0;
		end
		if (col_pos >= MAX_WIDTH) col_pos = MAX_WIDTH - 1;
		// A shrunken width makes any column at or past the new end the last one.
		at_end = col_pos >= w - 1;

		// Sum in sixteenths, then truncate toward zero exactly once.
		incoming = right_err;
		if (!top_row) incoming += int'(row_sums[col_pos]);
		adjusted = int'(pixel) + incoming / 16;
		is_white = adjusted > int'(threshold_reg);
		qerr     = adjusted - (is_white ? 255 : 0);

		// Close the lower-left sum with this pixel's 3/16 share.
		if (col_pos > 0) row_sums[col_pos - 1] = ERR_W'(below_left_err + 3 * qerr);
		below_left_err = below_err + 5 * qerr;
		below_err      = qerr;

		if (at_end) begin
			// Drop the right and lower-right shares at the edge.
			row_sums[col_pos] = ERR_W'(below_left_err);
			col_pos        = 0;
			top_row        = 1'b0;
			right_err      = 0;
			below_err      = 0;
			below_left_err = 0;
		end else begin
			right_err = 7 * qerr;
			col_pos++;
		end
		return is_white;
	endfunction

	task automatic report(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
	endtask

	function automatic void queue_pixel(input logic [PIX_W-1:0] pixel, input logic first);
		pixel_txn_t txn;
		txn.pixel          = pixel;
		txn.first_of_image = first;
		pixels_to_send.push_back(txn);
		items_queued++;
	endfunction

	// Favor the extremes and the values around the current threshold.
	function automatic logic [PIX_W-1:0] rand_pixel();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return threshold_reg ^ PIX_W'($urandom_range(0, 3));
			default: return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [THR_W-1:0] pick_threshold();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			default: return THR_W'($urandom_range(0, 255));
		endcase
	endfunction

	// Queue part of an image; now and then restart the image mid-stream.
	function automatic void queue_image_part(input int unsigned count, input bit opens_image);
		for (int unsigned i = 0; i < count; i++)
			queue_pixel(rand_pixel(), (i == 0 && opens_image) || $urandom_range(0, 63) == 0);
	endfunction

	// Hold until every pixel is taken and every decision has come back, then
	// let the two-stage pipeline settle.
	task automatic wait_drained();
		do @(posedge clk);
		while (pixels_to_send.size() != 0 || expected_white.size() != 0 || pix.valid);
		repeat (4) @(posedge clk);
	endtask

	// Write a register over APB, read it straight back, update the shadow.
	task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
		logic [PDATA_W-1:0] mask;
		logic [PDATA_W-1:0] readback;

		mask = (idx == REG_THRESHOLD) ? PDATA_W'((1 << THR_W) - 1) : PDATA_W'((1 << LW_W) - 1);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		// The write lands here; go straight into the read setup phase.
		@(posedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		readback = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (readback !== (value & mask))
			report($sformatf("register %s reads 0x%0h, wrote 0x%0h", idx.name(), readback,
				value & mask));
		if (idx == REG_THRESHOLD) threshold_reg = value[THR_W-1:0];
		else line_width_reg = value[LW_W-1:0];
	endtask

	// Pixel source: offer the head of the queue, hold it until taken, and
	// predict its decision at the edge where the transaction happens.
	always @(posedge clk) begin : pixel_drive
		bit taken;
		if (arst_n) begin
			taken = pix.valid && pix.ready;
			if (taken) begin
				expected_white.push_back(dither_pixel(pix.pixel, pix.first_of_image));
				void'(pixels_to_send.pop_front());
			end
			// Start a gap only between transactions, never under an offered pixel.
			if (src_gap > 0) src_gap--;
			else if (!steady && (taken || !pix.valid) && $urandom_range(0, 15) == 0)
				src_gap = $urandom_range(1, 10);
			if (!pix.valid || taken) begin
				if (src_gap == 0 && pixels_to_send.size() != 0) begin
					pix.valid          <= 1'b1;
					pix.pixel          <= pixels_to_send[0].pixel;
					pix.first_of_image <= pixels_to_send[0].first_of_image;
				end else begin
					pix.valid <= 1'b0;
				end
			end
		end
	end

	// Result sink: compare each decision with the oldest prediction and stall
	// in random bursts.
	always @(posedge clk) begin : result_check
		bit want;
		if (arst_n) begin
			if (res.valid && res.ready) begin
				if (expected_white.size() == 0) begin
					report($sformatf("result %0d white=%0b with no pixel pending",
						results_seen, res.white));
				end else begin
					want = expected_white.pop_front();
					if (res.white !== want)
						report($sformatf("result %0d white=%0b, predicted %0b",
							results_seen, res.white, want));
				end
				results_seen++;
			end
			if (dst_gap > 0) dst_gap--;
			else if (!steady && $urandom_range(0, 15) == 0) dst_gap = $urandom_range(1, 10);
			res.ready <= (dst_gap == 0);
		end
	end

	// Watchdog: count cycles in which no transaction moves on any port.
	always @(posedge clk) begin
		if (!arst_n || psel || (pix.valid && pix.ready) || (res.valid && res.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_error_diffusion_dither NOT OK");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned      eff;
		int unsigned      count;
		int               random_end;
		logic [LW_W-1:0]  raw_width;

		pix.valid          = 1'b0;
		pix.pixel          = '0;
		pix.first_of_image = 1'b0;
		res.ready          = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Out of reset: default width and threshold, no image start, values
		// on both sides of the threshold.
		queue_pixel(8'd0, 1'b0);
		queue_pixel(8'd255, 1'b0);
		queue_pixel(8'd128, 1'b0);
		queue_pixel(8'd129, 1'b0);

		// Shrink the width mid-row: column 4 becomes the last of its row.
		wait_drained();
		write_reg(REG_LINE_WIDTH, 3);
		queue_pixel(8'd200, 1'b0);
		queue_pixel(8'd17, 1'b0);
		queue_pixel(8'd90, 1'b0);
		queue_pixel(8'd255, 1'b0);
		queue_pixel(8'd1, 1'b0);

		// Width zero acts as one column; threshold at its floor.
		wait_drained();
		write_reg(REG_THRESHOLD, 0);
		write_reg(REG_LINE_WIDTH, 0);
		queue_pixel(8'd0, 1'b0);
		queue_pixel(8'd0, 1'b0);
		queue_pixel(8'd255, 1'b0);

		// Width above the buffer clamps to it; growing needs a new image.
		wait_drained();
		write_reg(REG_THRESHOLD, 255);
		write_reg(REG_LINE_WIDTH, (1 << LW_W) - 1);
		queue_pixel(8'd255, 1'b1);
		queue_pixel(8'd254, 1'b0);
		queue_pixel(8'd0, 1'b0);
		queue_pixel(8'd255, 1'b0);
		queue_pixel(8'd7, 1'b0);

		wait_drained();
		write_reg(REG_THRESHOLD, 128);
		write_reg(REG_LINE_WIDTH, MAX_WIDTH);
		queue_pixel(8'd130, 1'b0);
		queue_pixel(8'd126, 1'b0);

		// Cut a very long row short far past the new end.
		wait_drained();
		write_reg(REG_THRESHOLD, 100);
		write_reg(REG_LINE_WIDTH, 2);
		queue_pixel(8'd100, 1'b0);
		queue_pixel(8'd101, 1'b0);
		queue_pixel(8'd250, 1'b0);
		queue_pixel(8'd3, 1'b0);

		// Random images: each opens with an image start after a new setting,
		// so a wider row never reads error sums that were never written.
		random_end = items_queued + RANDOM_ITEMS;
		while (items_queued < random_end - STEADY_TAIL) begin
			wait_drained();
			steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 2) != 0) write_reg(REG_THRESHOLD, pick_threshold());
			case ($urandom_range(0, 19))
				0:          raw_width = '0;
				1:          raw_width = LW_W'($urandom_range(MAX_WIDTH + 1, (1 << LW_W) - 1));
				2:          raw_width = LW_W'(MAX_WIDTH);
				3, 4, 5:    raw_width = LW_W'($urandom_range(17, 64));
				default:    raw_width = LW_W'($urandom_range(1, 16));
			endcase
			write_reg(REG_LINE_WIDTH, raw_width);
			eff = effective_width(line_width_reg);
			// Keep long rows to at most 30 pixels; they stay in the near columns.
			if (eff > 64) count = $urandom_range(1, 30);
			else count = eff * $urandom_range(1, 4) + $urandom_range(0, eff - 1);
			queue_image_part(count, 1'b1);

			// Now and then narrow the rows inside the image; never widen them.
			if ($urandom_range(0, 3) == 0) begin
				wait_drained();
				write_reg(REG_LINE_WIDTH, $urandom_range(0, eff > 64 ? 64 : eff));
				if ($urandom_range(0, 1) == 0) write_reg(REG_THRESHOLD, pick_threshold());
				eff   = effective_width(line_width_reg);
				count = eff * $urandom_range(1, 3) + $urandom_range(0, eff - 1);
				queue_image_part(count, 1'b0);
			end
		end

		// Final stretch: one more image with no idling on either side.
		wait_drained();
		steady = 1'b1;
		write_reg(REG_LINE_WIDTH, $urandom_range(1, 64));
		queue_image_part(STEADY_TAIL, 1'b1);

		wait_drained();
		if (mismatch_count == 0)
			$display("tb_error_diffusion_dither OK");
		else
			$display("tb_error_diffusion_dither NOT OK");
		$finish;
	end

endmodule

FILE: error_diffusion_dither.f
rtl/efd_pkg.sv
rtl/efd_if.sv
rtl/efd_regs.sv
rtl/error_diffusion_dither.sv
sim/tb_error_diffusion_dither.sv
